/* design/rbfp_pkg.sv */
// Package for the ring buffer FIFO with peek.
// Holds sizes, request and status codes and the structs passed between modules.
// No dependencies.
package rbfp_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 8;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OFS_W      = 4;
    localparam int OCC_W      = 5;
    localparam int SUM_W      = ((PTR_W > OFS_W) ? PTR_W : OFS_W) + 1;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_GET   = 2'd1,
        REQ_PEEK  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // memory access issued by the controller
    typedef struct packed {
        logic                  we;
        logic [PTR_W-1:0]      waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [PTR_W-1:0]      raddr;
    } t_ram_req;

    // result bookkeeping, valid in the cycle after a transfer
    typedef struct packed {
        logic             done;
        t_status          status;
        logic             data_sel;
        logic [CNT_W-1:0] count;
    } t_rsp;

endpackage

/* design/rbfp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module rbfp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

/* design/rbfp_ctrl.sv */
// Pointer and occupancy controller of the ring buffer FIFO with peek.
// Decides each request, issues the memory access, registers the result status.
// Depends on rbfp_pkg.
module rbfp_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  rbfp_pkg::t_req                 i_req,
    input  logic [rbfp_pkg::DATA_WIDTH-1:0] i_data,
    input  logic [rbfp_pkg::OFS_W-1:0]     i_offset,
    output rbfp_pkg::t_ram_req             o_ram,
    output rbfp_pkg::t_rsp                 o_rsp
);

    logic [rbfp_pkg::PTR_W-1:0] r_wp, n_wp;
    logic [rbfp_pkg::PTR_W-1:0] r_rp, n_rp;
    logic [rbfp_pkg::CNT_W-1:0] r_count, n_count;
    logic                       r_done;
    rbfp_pkg::t_status          r_status, n_status;
    logic                       r_data_sel, n_data_sel;

    logic [rbfp_pkg::PTR_W-1:0] wp_inc, rp_inc;
    logic [rbfp_pkg::SUM_W-1:0] pos_sum, pos_wrap;
    logic                       is_full, cnt_zero, ofs_ok;

    assign is_full  = (r_count == rbfp_pkg::CNT_W'(rbfp_pkg::DEPTH));
    assign cnt_zero = (r_count == '0);
    assign wp_inc   = (r_wp == rbfp_pkg::PTR_W'(rbfp_pkg::DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign rp_inc   = (r_rp == rbfp_pkg::PTR_W'(rbfp_pkg::DEPTH - 1)) ? '0 : r_rp + 1'b1;

    // peek position: offset < count <= DEPTH, so one subtract wraps it
    assign pos_sum  = rbfp_pkg::SUM_W'(r_rp) + rbfp_pkg::SUM_W'(i_offset);
    assign pos_wrap = (pos_sum >= rbfp_pkg::SUM_W'(rbfp_pkg::DEPTH))
                    ? pos_sum - rbfp_pkg::SUM_W'(rbfp_pkg::DEPTH) : pos_sum;
    assign ofs_ok   = (rbfp_pkg::SUM_W'(i_offset) < rbfp_pkg::SUM_W'(r_count));

    always_comb begin
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_count    = r_count;
        n_status   = rbfp_pkg::ST_OK;
        n_data_sel = 1'b0;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_wp;
        o_ram.wdata = i_data;
        o_ram.re    = 1'b0;
        o_ram.raddr = r_rp;
        if (i_start) begin
            case (i_req)
                rbfp_pkg::REQ_PUT: begin
                    if (is_full) begin
                        n_status = rbfp_pkg::ST_FULL;
                    end else begin
                        o_ram.we = 1'b1;
                        n_wp     = wp_inc;
                        n_count  = r_count + 1'b1;
                    end
                end
                rbfp_pkg::REQ_GET: begin
                    if (cnt_zero) begin
                        n_status = rbfp_pkg::ST_EMPTY;
                    end else begin
                        o_ram.re   = 1'b1;
                        n_data_sel = 1'b1;
                        n_rp       = rp_inc;
                        n_count    = r_count - 1'b1;
                    end
                end
                rbfp_pkg::REQ_PEEK: begin
                    if (!ofs_ok) begin
                        n_status = rbfp_pkg::ST_RANGE;
                    end else begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = pos_wrap[rbfp_pkg::PTR_W-1:0];
                        n_data_sel  = 1'b1;
                    end
                end
                rbfp_pkg::REQ_CLEAR: begin
                    n_wp    = '0;
                    n_rp    = '0;
                    n_count = '0;
                end
                default: begin
                    n_status = rbfp_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_rp       <= '0;
            r_count    <= '0;
            r_done     <= 1'b0;
            r_status   <= rbfp_pkg::ST_OK;
            r_data_sel <= 1'b0;
        end else begin
            r_wp       <= n_wp;
            r_rp       <= n_rp;
            r_count    <= n_count;
            r_done     <= i_start;
            r_status   <= n_status;
            r_data_sel <= n_data_sel;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.status   = r_status;
    assign o_rsp.data_sel = r_data_sel;
    assign o_rsp.count    = r_count;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rbfp_pkg::CNT_W'(rbfp_pkg::DEPTH))
        else $error("occupancy above depth");

    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status == rbfp_pkg::ST_FULL) |-> is_full)
        else $error("put refused while not full");

    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && i_req == rbfp_pkg::REQ_PUT && !is_full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted put did not grow occupancy");

    a_read_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_data_sel) |-> (r_status == rbfp_pkg::ST_OK))
        else $error("data selected on refused request");
`endif

endmodule

/* design/ring_buffer_fifo_with_peek_unit.sv */
// Top level of the ring buffer FIFO with peek.
// Instantiates rbfp_ctrl and rbfp_ram; depends on rbfp_pkg.
//
// Usage:
//   A request (put, get, peek or clear) is transferred at a rising edge with
//   start high and busy low. busy is never raised: a new request may follow
//   in every cycle.
//   Exactly one result per request appears on the o_ result ports in the cycle
//   after the transfer, for one cycle, flagged by o_done. The receiver cannot
//   stall; it must take the result in that cycle.
//   Throughput is one request per cycle. The word for a get or peek comes
//   from the storage RAM read port, whose read data is registered; pointers
//   and occupancy are updated at the transfer edge, so a following request
//   sees them at once.
//   A put writes the RAM at the transfer edge; reads only touch entries below
//   the occupancy, so a read never hits the entry being written.
//   Reset (i_rst_n low, synchronous) clears the pointers, occupancy and the
//   result strobe. RAM contents are not cleared; entries are only read after
//   being written. A clear request does the same as reset for the pointers.
//   data_out is zero for put, clear and any refused request.
module ring_buffer_fifo_with_peek_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_req_type,
    input  logic [rbfp_pkg::DATA_WIDTH-1:0] i_data_in,
    input  logic [rbfp_pkg::OFS_W-1:0]      i_peek_offset,
    output logic                            o_done,
    output logic [1:0]                      o_status,
    output logic [rbfp_pkg::DATA_WIDTH-1:0] o_data_out,
    output logic [rbfp_pkg::OCC_W-1:0]      o_occupancy,
    output logic                            o_is_full,
    output logic                            o_is_empty
);

    rbfp_pkg::t_ram_req                ram_req;
    rbfp_pkg::t_rsp                    rsp;
    logic [rbfp_pkg::DATA_WIDTH-1:0]   rdata;

    // one request per cycle, never stalls
    assign busy = 1'b0;

    rbfp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (rbfp_pkg::t_req'(i_req_type)),
        .i_data   (i_data_in),
        .i_offset (i_peek_offset),
        .o_ram    (ram_req),
        .o_rsp    (rsp)
    );

    rbfp_ram #(
        .WIDTH  (rbfp_pkg::DATA_WIDTH),
        .DEPTH  (rbfp_pkg::DEPTH),
        .ADDR_W (rbfp_pkg::PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    assign o_done      = rsp.done;
    assign o_status    = rsp.status;
    assign o_data_out  = rsp.data_sel ? rdata : '0;
    assign o_occupancy = rbfp_pkg::OCC_W'(rsp.count);
    assign o_is_full   = (rsp.count == rbfp_pkg::CNT_W'(rbfp_pkg::DEPTH));
    assign o_is_empty  = (rsp.count == '0);

`ifndef SYNTHESIS
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("no result after transfer");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_is_full && o_is_empty))
        else $error("full and empty together");

    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != rbfp_pkg::ST_OK) |-> (o_data_out == '0))
        else $error("data on refused request");
`endif

endmodule

/* bench/tb_ring_buffer_fifo_with_peek_unit.sv */
// Self-checking bench for ring_buffer_fifo_with_peek_unit: directed corner cases,
// then random put/get/peek/clear traffic scored against an in-bench FIFO predictor.
// Depends on rbfp_pkg and the design sources under design/.
module tb_ring_buffer_fifo_with_peek_unit;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 4;      // extra wait after the last result is checked

    // one expected result of a request
    typedef struct {
        rbfp_pkg::t_status               status;
        logic [rbfp_pkg::DATA_WIDTH-1:0] data;
        logic [rbfp_pkg::OCC_W-1:0]      occ;
        logic                            full;
        logic                            empty;
    } t_fifo_result;

    // FIFO predictor plus the queue of results still owed by the block
    class t_fifo_scoreboard;
        logic [rbfp_pkg::DATA_WIDTH-1:0] ring [rbfp_pkg::DEPTH];
        int unsigned           wr_ptr;
        int unsigned           rd_ptr;
        bit                    full;
        t_fifo_result          owed [$];
        int                    errors;
        int                    req_count [4];
        int                    status_count [4];
        int                    full_hits;

        function new();
            wr_ptr = 0;
            rd_ptr = 0;
            full   = 0;
            errors = 0;
            full_hits = 0;
            foreach (req_count[i]) req_count[i] = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        function int unsigned held();
            if (full) return rbfp_pkg::DEPTH;
            if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
            return rbfp_pkg::DEPTH + wr_ptr - rd_ptr;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // predict the result of an accepted request and update the FIFO state
        function void note_request(rbfp_pkg::t_req req,
                                   logic [rbfp_pkg::DATA_WIDTH-1:0] word,
                                   logic [rbfp_pkg::OFS_W-1:0] ofs);
            t_fifo_result exp;
            int unsigned  count;
            exp.status = rbfp_pkg::ST_OK;
            exp.data   = '0;
            count      = held();
            case (req)
                rbfp_pkg::REQ_PUT: begin
                    if (full) begin
                        exp.status = rbfp_pkg::ST_FULL;
                    end else begin
                        ring[wr_ptr] = word;
                        wr_ptr = (wr_ptr + 1) % rbfp_pkg::DEPTH;
                        full   = (wr_ptr == rd_ptr);
                    end
                end
                rbfp_pkg::REQ_GET: begin
                    if (count == 0) begin
                        exp.status = rbfp_pkg::ST_EMPTY;
                    end else begin
                        exp.data = ring[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % rbfp_pkg::DEPTH;
                        full   = 0;
                    end
                end
                rbfp_pkg::REQ_PEEK: begin
                    if (ofs >= count) exp.status = rbfp_pkg::ST_RANGE;
                    else exp.data = ring[(rd_ptr + ofs) % rbfp_pkg::DEPTH];
                end
                default: begin
                    wr_ptr = 0;
                    rd_ptr = 0;
                    full   = 0;
                end
            endcase
            count     = held();
            exp.occ   = count[rbfp_pkg::OCC_W-1:0];
            exp.full  = full;
            exp.empty = (count == 0);
            req_count[req]++;
            status_count[exp.status]++;
            if (full) full_hits++;
            owed.push_back(exp);
        endfunction

        function void compare_field(string name, logic [7:0] exp, logic [7:0] act);
            if (act !== exp) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
            end
        endfunction

        // check one result against the oldest expectation
        function void check_result(logic [1:0] st, logic [rbfp_pkg::DATA_WIDTH-1:0] d,
                                   logic [rbfp_pkg::OCC_W-1:0] occ, logic f, logic e);
            t_fifo_result exp;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding, expected none, %s %0d %s %0d",
                         $time, "actual status", st, "data", d);
                return;
            end
            exp = owed.pop_front();
            compare_field("status", 8'(exp.status), 8'(st));
            compare_field("data_out", 8'(exp.data), 8'(d));
            compare_field("occupancy", 8'(exp.occ), 8'(occ));
            compare_field("is_full", 8'(exp.full), 8'(f));
            compare_field("is_empty", 8'(exp.empty), 8'(e));
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic [1:0]                      i_req_type;
    logic [rbfp_pkg::DATA_WIDTH-1:0] i_data_in;
    logic [rbfp_pkg::OFS_W-1:0]      i_peek_offset;
    logic                            o_done;
    logic [1:0]                      o_status;
    logic [rbfp_pkg::DATA_WIDTH-1:0] o_data_out;
    logic [rbfp_pkg::OCC_W-1:0]      o_occupancy;
    logic                            o_is_full;
    logic                            o_is_empty;

    t_fifo_scoreboard sb;
    int               cycle_count = 0;
    int               idle_pct;

    ring_buffer_fifo_with_peek_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_data_in     (i_data_in),
        .i_peek_offset (i_peek_offset),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_occupancy   (o_occupancy),
        .o_is_full     (o_is_full),
        .o_is_empty    (o_is_empty)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // monitor: check the result of the previous transfer first, then log the
    // transfer at this edge, so ordering in the queue never depends on the
    // scheduler
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_done === 1'b1)
                sb.check_result(o_status, o_data_out, o_occupancy, o_is_full, o_is_empty);
            if (start === 1'b1 && busy === 1'b0)
                sb.note_request(rbfp_pkg::t_req'(i_req_type), i_data_in, i_peek_offset);
        end
    end

    // an idle slot on the request side: start is dropped at a falling edge
    task automatic idle_cycle();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // called just after a falling edge: present the request and hold it
    // until the transfer happens
    task automatic put_on_bus(rbfp_pkg::t_req req, logic [rbfp_pkg::DATA_WIDTH-1:0] word,
                              logic [rbfp_pkg::OFS_W-1:0] ofs);
        start         <= 1'b1;
        i_req_type    <= req;
        i_data_in     <= word;
        i_peek_offset <= ofs;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic send_directed(rbfp_pkg::t_req req, logic [rbfp_pkg::DATA_WIDTH-1:0] word,
                                 logic [rbfp_pkg::OFS_W-1:0] ofs);
        while ($urandom_range(99) < idle_pct) idle_cycle();
        @(negedge i_clk);
        put_on_bus(req, word, ofs);
    endtask

    // random traffic in bursts that lean toward filling, draining or neither,
    // so occupancy sweeps from empty to full and the pointers wrap often
    task automatic run_random(int n_items, int gap_pct);
        int   burst_left;
        int   lean;
        int   pick;
        rbfp_pkg::t_req req;
        logic [rbfp_pkg::OFS_W-1:0] ofs;
        int unsigned count;
        burst_left = 0;
        lean       = 0;
        for (int n = 0; n < n_items; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(8, 40);
                lean       = $urandom_range(2);
            end
            burst_left--;
            while ($urandom_range(99) < gap_pct) idle_cycle();
            @(negedge i_clk);
            pick = $urandom_range(99);
            if (pick < 2) begin
                req = rbfp_pkg::REQ_CLEAR;
            end else if (lean == 0) begin
                req = (pick < 62) ? rbfp_pkg::REQ_PUT :
                      (pick < 80) ? rbfp_pkg::REQ_GET : rbfp_pkg::REQ_PEEK;
            end else if (lean == 1) begin
                req = (pick < 25) ? rbfp_pkg::REQ_PUT :
                      (pick < 70) ? rbfp_pkg::REQ_GET : rbfp_pkg::REQ_PEEK;
            end else begin
                req = (pick < 40) ? rbfp_pkg::REQ_PUT :
                      (pick < 70) ? rbfp_pkg::REQ_GET : rbfp_pkg::REQ_PEEK;
            end
            // mostly legal peek offsets, some out of range
            count = sb.held();
            if (count > 0 && $urandom_range(3) != 0)
                ofs = rbfp_pkg::OFS_W'($urandom_range(count - 1));
            else
                ofs = rbfp_pkg::OFS_W'($urandom_range(15));
            put_on_bus(req, rbfp_pkg::DATA_WIDTH'($urandom_range(255)), ofs);
        end
    endtask

    initial begin
        sb            = new();
        idle_pct      = 34;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_req_type    = rbfp_pkg::REQ_PUT;
        i_data_in     = '0;
        i_peek_offset = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty corners, fill to full with extreme words, full corners
        send_directed(rbfp_pkg::REQ_GET, 8'hA5, 4'd0);
        send_directed(rbfp_pkg::REQ_PEEK, 8'h00, 4'd15);
        send_directed(rbfp_pkg::REQ_PUT, 8'hFF, 4'd15);
        send_directed(rbfp_pkg::REQ_PUT, 8'h00, 4'd0);
        for (int k = 2; k < rbfp_pkg::DEPTH; k++)
            send_directed(rbfp_pkg::REQ_PUT, rbfp_pkg::DATA_WIDTH'($urandom_range(255)), 4'd0);
        send_directed(rbfp_pkg::REQ_PUT, 8'h5A, 4'd0);     // refused, FIFO full
        send_directed(rbfp_pkg::REQ_PEEK, 8'h00, 4'd15);   // newest entry
        send_directed(rbfp_pkg::REQ_PEEK, 8'hFF, 4'd0);    // oldest entry
        send_directed(rbfp_pkg::REQ_GET, 8'h00, 4'd0);
        send_directed(rbfp_pkg::REQ_CLEAR, 8'hFF, 4'hF);
        send_directed(rbfp_pkg::REQ_GET, 8'h00, 4'd0);     // empty again after clear

        // random: sender idles moderately, then heavily, then never
        run_random(400, 34);
        run_random(400, 61);
        run_random(400, 0);

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("Covered %0d puts, %0d gets, %0d peeks, %0d clears; full seen %0d times.",
                 sb.req_count[rbfp_pkg::REQ_PUT], sb.req_count[rbfp_pkg::REQ_GET],
                 sb.req_count[rbfp_pkg::REQ_PEEK], sb.req_count[rbfp_pkg::REQ_CLEAR],
                 sb.full_hits);
        $display("Status mix: %0d ok, %0d refused full, %0d empty get, %0d peek out of range.",
                 sb.status_count[rbfp_pkg::ST_OK], sb.status_count[rbfp_pkg::ST_FULL],
                 sb.status_count[rbfp_pkg::ST_EMPTY], sb.status_count[rbfp_pkg::ST_RANGE]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* sim.f */
design/rbfp_pkg.sv
design/rbfp_ram.sv
design/rbfp_ctrl.sv
design/ring_buffer_fifo_with_peek_unit.sv
bench/tb_ring_buffer_fifo_with_peek_unit.sv
